>>> hdl/integer_to_text_formatter_top_defines.svh
// assertion macros shared by the formatter rtl
`ifndef INTEGER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ITF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/itf_pkg.sv
`timescale 1ns / 1ps

package itf_pkg;

    // data widths
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = 5;
    localparam int LEN_W      = 7;
    localparam int CNT_W      = 6;
    localparam int BIT_W      = 5;
    localparam int PRE_CHARS  = 4;
    localparam int PRE_CNT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // a 32-bit magnitude has at most 32 digits (radix 2)
    localparam int MAX_DIGITS = 32;

    // longest body that is still printed
    localparam int BUFFER_SIZE = 64;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_W - 1);

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA_OFS = 8'h57;
    localparam logic [CHAR_W-1:0] CH_X         = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS      = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX       = 3'd0,
        CFG_MIN_WIDTH   = 3'd1,
        CFG_PRECISION   = 3'd2,
        CFG_ALT_FORM    = 3'd3,
        CFG_FORCE_SIGN  = 3'd4,
        CFG_SPACE_FLAG  = 3'd5,
        CFG_ZERO_PAD    = 3'd6,
        CFG_FLUSH_LEFT  = 3'd7
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_LEN  = 6'b000100,
        S_PAD  = 6'b001000,
        S_EMIT = 6'b010000,
        S_ERR  = 6'b100000
    } t_state;

    // digit value to lower-case ascii
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = ext + CH_ZERO;
        end else begin
            digit_char = ext + CH_ALPHA_OFS;
        end
    endfunction

endpackage

>>> hdl/integer_to_text_formatter_top.sv
`timescale 1ns / 1ps
`include "integer_to_text_formatter_top_defines.svh"

// Integer to text formatter. Each transfer on the slave stream carries one
// signed 32-bit value; the block answers with its printf-style text on the
// master stream, one ASCII character per transfer, tlast on the final one.
// The text is: optional "0"/"0x" prefix (octal/hex with alt_form), sign
// ('-' when negative, '+' with force_sign unless alt_form), a space when
// space_flag and the value is not negative, zeros up to the precision,
// then the magnitude digits in the configured radix (2..16, clamped),
// lower-case letters. The body is padded to min_width with spaces or
// zeros, on the left or, with flush_left, on the right; zero padding goes
// in front of prefix and sign. A body longer than BUFFER_SIZE characters
// (64 by default) yields a single transfer with tdata 0, tlast 1 and
// tuser (error) 1.
// Timing: digits come from one shared restoring divider that retires one
// quotient bit per cycle. After the input transfer the value passes
// through division (S_DIV), the length step (S_LEN) and the padding
// step (S_PAD); then S_EMIT loads the output register with one
// character per cycle while the master side keeps tready high.
// The slave side is ready only while the block is idle; it becomes ready
// again as soon as the last character sits in the output register,
// before that character is taken.
// Configuration writes (ready always high) must be made while idle:
// index 0 radix, 1 min_width, 2 precision, 3 alt_form, 4 force_sign,
// 5 space_flag, 6 zero_pad, 7 flush_left; data in the low bits.
module integer_to_text_formatter_top #(
    parameter int BUFFER_SIZE = itf_pkg::BUFFER_SIZE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [itf_pkg::VALUE_W-1:0]     i_s_axis_tdata,   // [31:0] value
    // output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [itf_pkg::CHAR_W-1:0]      o_m_axis_tdata,   // [7:0] char_code
    output logic                            o_m_axis_tlast,   // last
    output logic                            o_m_axis_tuser,   // [0] error
    // register write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [itf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [itf_pkg::RADIX_W-1:0] r_radix;
    logic [itf_pkg::CNT_W-1:0]   r_min_width;
    logic [itf_pkg::CNT_W-1:0]   r_precision;
    logic                        r_alt_form;
    logic                        r_force_sign;
    logic                        r_space_flag;
    logic                        r_zero_pad;
    logic                        r_flush_left;

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    itf_pkg::t_state r_state, n_state;

    logic                            r_neg;
    logic [itf_pkg::VALUE_W-1:0]     r_quo;      // dividend, becomes quotient
    logic [itf_pkg::DIGIT_W-1:0]     r_rem;      // partial remainder
    logic [itf_pkg::BIT_W-1:0]       r_bit;      // quotient bit counter
    logic [itf_pkg::CNT_W-1:0]       r_ndig;     // digits produced
    logic [itf_pkg::DIGIT_W-1:0]     r_dig [itf_pkg::MAX_DIGITS];  // digit stack

    logic [itf_pkg::PRE_CHARS*itf_pkg::CHAR_W-1:0] r_pre;  // prefix chars, first low
    logic [itf_pkg::PRE_CNT_W-1:0]   r_pre_len;
    logic [itf_pkg::LEN_W-1:0]       r_zend;     // body index where digits start
    logic [itf_pkg::LEN_W-1:0]       r_blen;
    logic [itf_pkg::LEN_W-1:0]       r_pad;
    logic [itf_pkg::LEN_W-1:0]       r_total;
    logic [itf_pkg::LEN_W-1:0]       r_k;        // output position

    // output register
    logic                            r_tvalid;
    logic [itf_pkg::CHAR_W-1:0]      r_tdata;
    logic                            r_tlast;
    logic                            r_tuser;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic                            w_in_xfer;
    logic                            w_load;
    logic [itf_pkg::RADIX_W-1:0]     w_radix;
    logic [itf_pkg::RADIX_W-1:0]     w_shift;
    logic                            w_ge;
    logic [itf_pkg::DIGIT_W-1:0]     w_rem_nx;
    logic [itf_pkg::VALUE_W-1:0]     w_quo_nx;
    logic                            w_digit_done;

    logic [itf_pkg::PRE_CHARS*itf_pkg::CHAR_W-1:0] w_pre;
    logic [itf_pkg::PRE_CNT_W-1:0]   w_pre_cnt;
    logic                            w_sign_on;
    logic [itf_pkg::CHAR_W-1:0]      w_sign_ch;
    logic [itf_pkg::CNT_W-1:0]       w_dig_span;   // max(precision, digits)
    logic [itf_pkg::CNT_W-1:0]       w_zeros;

    logic [itf_pkg::LEN_W-1:0]       w_fw_ext;
    logic                            w_too_long;
    logic [itf_pkg::LEN_W-1:0]       w_body_idx;
    logic                            w_in_pad;
    logic                            w_in_pre;
    logic                            w_in_zero;
    logic [itf_pkg::CHAR_W-1:0]      w_pad_ch;
    logic [itf_pkg::CHAR_W-1:0]      w_char;
    logic                            w_last_char;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load    = !r_tvalid || i_m_axis_tready;

    // radix clamped to 2..16
    assign w_radix = (r_radix < itf_pkg::RADIX_MIN) ? itf_pkg::RADIX_MIN :
                     (r_radix > itf_pkg::RADIX_MAX) ? itf_pkg::RADIX_MAX : r_radix;

    // one restoring division step: shift in the next dividend bit,
    // subtract the radix when it fits
    assign w_shift      = {r_rem, r_quo[itf_pkg::VALUE_W-1]};
    assign w_ge         = (w_shift >= w_radix);
    assign w_rem_nx     = w_ge ? itf_pkg::DIGIT_W'(w_shift - w_radix)
                               : w_shift[itf_pkg::DIGIT_W-1:0];
    assign w_quo_nx     = {r_quo[itf_pkg::VALUE_W-2:0], w_ge};
    assign w_digit_done = (r_bit == itf_pkg::BIT_LAST);

    // prefix, sign and space, packed in output order
    assign w_sign_on = r_neg || (r_force_sign && !r_alt_form);
    assign w_sign_ch = r_neg ? itf_pkg::CH_MINUS : itf_pkg::CH_PLUS;

    always_comb begin
        w_pre     = '0;
        w_pre_cnt = '0;
        if (r_alt_form && (w_radix == itf_pkg::RADIX_OCT || w_radix == itf_pkg::RADIX_HEX)) begin
            w_pre[itf_pkg::CHAR_W-1:0] = itf_pkg::CH_ZERO;
            w_pre_cnt                  = 3'd1;
        end
        if (r_alt_form && w_radix == itf_pkg::RADIX_HEX) begin
            w_pre[2*itf_pkg::CHAR_W-1:itf_pkg::CHAR_W] = itf_pkg::CH_X;
            w_pre_cnt                                  = 3'd2;
        end
        if (w_sign_on) begin
            w_pre[{w_pre_cnt[1:0], 3'b000} +: itf_pkg::CHAR_W] = w_sign_ch;
            w_pre_cnt = w_pre_cnt + 3'd1;
        end
        if (!r_neg && r_space_flag) begin
            w_pre[{w_pre_cnt[1:0], 3'b000} +: itf_pkg::CHAR_W] = itf_pkg::CH_SPACE;
            w_pre_cnt = w_pre_cnt + 3'd1;
        end
    end

    assign w_dig_span = (r_precision > r_ndig) ? r_precision : r_ndig;
    assign w_zeros    = (r_precision > r_ndig) ? (r_precision - r_ndig) : '0;

    // padding decision
    assign w_fw_ext   = {1'b0, r_min_width};
    assign w_too_long = (r_blen > itf_pkg::LEN_W'(BUFFER_SIZE));

    // character select for the current output position
    assign w_body_idx  = r_flush_left ? r_k : (r_k - r_pad);
    assign w_in_pad    = (!r_flush_left && (r_k < r_pad)) ||
                         (r_flush_left && (r_k >= r_blen));
    assign w_in_pre    = (w_body_idx < {4'b0000, r_pre_len});
    assign w_in_zero   = (w_body_idx < r_zend);
    assign w_pad_ch    = r_zero_pad ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
    assign w_last_char = (r_k == (r_total - 7'd1));

    always_comb begin
        if (w_in_pad) begin
            w_char = w_pad_ch;
        end else if (w_in_pre) begin
            w_char = r_pre[itf_pkg::CHAR_W-1:0];
        end else if (w_in_zero) begin
            w_char = itf_pkg::CH_ZERO;
        end else begin
            w_char = itf_pkg::digit_char(r_dig[0]);
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itf_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = itf_pkg::S_DIV;
            end
            itf_pkg::S_DIV: begin
                // stop once a digit leaves a zero quotient
                if (w_digit_done && (w_quo_nx == '0)) n_state = itf_pkg::S_LEN;
            end
            itf_pkg::S_LEN: begin
                n_state = itf_pkg::S_PAD;
            end
            itf_pkg::S_PAD: begin
                n_state = w_too_long ? itf_pkg::S_ERR : itf_pkg::S_EMIT;
            end
            itf_pkg::S_EMIT: begin
                if (w_load && w_last_char) n_state = itf_pkg::S_IDLE;
            end
            itf_pkg::S_ERR: begin
                if (w_load) n_state = itf_pkg::S_IDLE;
            end
            default: begin
                n_state = itf_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= itf_pkg::S_IDLE;
            r_radix       <= itf_pkg::RADIX_RESET;
            r_min_width   <= '0;
            r_precision   <= '0;
            r_alt_form    <= 1'b0;
            r_force_sign  <= 1'b0;
            r_space_flag  <= 1'b0;
            r_zero_pad    <= 1'b0;
            r_flush_left  <= 1'b0;
            r_bit         <= '0;
            r_ndig        <= '0;
            r_k           <= '0;
            r_tvalid      <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (itf_pkg::t_cfg_idx'(i_cfg_index))
                    itf_pkg::CFG_RADIX:       r_radix       <= i_cfg_data[itf_pkg::RADIX_W-1:0];
                    itf_pkg::CFG_MIN_WIDTH:   r_min_width   <= i_cfg_data;
                    itf_pkg::CFG_PRECISION:   r_precision   <= i_cfg_data;
                    itf_pkg::CFG_ALT_FORM:    r_alt_form    <= i_cfg_data[0];
                    itf_pkg::CFG_FORCE_SIGN:  r_force_sign  <= i_cfg_data[0];
                    itf_pkg::CFG_SPACE_FLAG:  r_space_flag  <= i_cfg_data[0];
                    itf_pkg::CFG_ZERO_PAD:    r_zero_pad    <= i_cfg_data[0];
                    itf_pkg::CFG_FLUSH_LEFT:  r_flush_left  <= i_cfg_data[0];
                endcase
            end

            if (r_state == itf_pkg::S_IDLE && w_in_xfer) begin
                r_bit  <= '0;
                r_ndig <= '0;
            end

            if (r_state == itf_pkg::S_DIV) begin
                r_bit <= r_bit + 5'd1;   // wraps to zero after the last bit
                if (w_digit_done) r_ndig <= r_ndig + 6'd1;
            end

            if (r_state == itf_pkg::S_PAD) begin
                r_k <= '0;
            end

            // output register valid
            if ((r_state == itf_pkg::S_EMIT || r_state == itf_pkg::S_ERR) && w_load) begin
                r_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_tvalid <= 1'b0;
            end

            if (r_state == itf_pkg::S_EMIT && w_load) begin
                r_k <= r_k + 7'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == itf_pkg::S_IDLE && w_in_xfer) begin
            r_neg <= i_s_axis_tdata[itf_pkg::VALUE_W-1];
            r_quo <= i_s_axis_tdata[itf_pkg::VALUE_W-1] ? (32'd0 - i_s_axis_tdata)
                                                         : i_s_axis_tdata;
            r_rem <= '0;
        end

        if (r_state == itf_pkg::S_DIV) begin
            r_quo <= w_quo_nx;
            if (w_digit_done) begin
                // push the new digit; the most significant ends on top
                r_rem    <= '0;
                r_dig[0] <= w_rem_nx;
                for (int i = 1; i < itf_pkg::MAX_DIGITS; i++) begin
                    r_dig[i] <= r_dig[i-1];
                end
            end else begin
                r_rem <= w_rem_nx;
            end
        end

        if (r_state == itf_pkg::S_LEN) begin
            r_pre     <= w_pre;
            r_pre_len <= w_pre_cnt;
            r_blen    <= {4'b0000, w_pre_cnt} + {1'b0, w_dig_span};
            r_zend    <= {4'b0000, w_pre_cnt} + {1'b0, w_zeros};
        end

        if (r_state == itf_pkg::S_PAD) begin
            if (r_min_width != '0 && w_fw_ext >= r_blen) begin
                r_pad   <= w_fw_ext - r_blen;
                r_total <= w_fw_ext;
            end else begin
                r_pad   <= '0;
                r_total <= r_blen;
            end
        end

        if (r_state == itf_pkg::S_EMIT && w_load) begin
            r_tdata <= w_char;
            r_tlast <= w_last_char;
            r_tuser <= 1'b0;
            if (!w_in_pad && w_in_pre) begin
                r_pre <= r_pre >> itf_pkg::CHAR_W;
            end
            if (!w_in_pad && !w_in_pre && !w_in_zero) begin
                // pop the digit stack
                for (int i = 0; i < itf_pkg::MAX_DIGITS - 1; i++) begin
                    r_dig[i] <= r_dig[i+1];
                end
            end
        end

        if (r_state == itf_pkg::S_ERR && w_load) begin
            r_tdata <= itf_pkg::CH_NUL;
            r_tlast <= 1'b1;
            r_tuser <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == itf_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tlast  = r_tlast;
    assign o_m_axis_tuser  = r_tuser;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an error transfer is always the sole, and so the final, one
    `ITF_ASSERT_NOW(a_err_is_last, r_tvalid && r_tuser, r_tlast, "error without last")
    // the output position never runs past the run length
    `ITF_ASSERT_NOW(a_pos_in_range, r_state == itf_pkg::S_EMIT, r_k < r_total, "position overrun")
    // a 32-bit magnitude never yields more digits than the stack holds
    `ITF_ASSERT_NOW(a_digits_fit, r_state == itf_pkg::S_LEN,
        r_ndig != '0 && r_ndig <= itf_pkg::CNT_W'(itf_pkg::MAX_DIGITS), "digit count out of range")
    // loading the final character returns the sequencer to idle
    `ITF_ASSERT_NEXT(a_last_to_idle, r_state == itf_pkg::S_EMIT && w_load && w_last_char,
        r_state == itf_pkg::S_IDLE && r_tvalid && r_tlast, "no return to idle after last")

endmodule

>>> dv/integer_to_text_formatter_top_test.sv
`timescale 1ns / 1ps

module integer_to_text_formatter_top_test;

    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 24;
    // longer than the slowest item, so the output register fills and the input stalls
    localparam int HOLD_CYCLES   = 3000;
    // slowest item is radix 2: 32 digits to divide out, plus the characters
    localparam int SETTLE_CYCLES = 1200;

    // one character of formatted text as it leaves the block
    typedef struct packed {
        logic [itf_pkg::CHAR_W-1:0] code;
        logic                       last;
        logic                       err;
    } t_text_char;

    // one full set of format registers
    typedef struct packed {
        logic [itf_pkg::RADIX_W-1:0] radix;
        logic [5:0]                  width;
        logic [5:0]                  prec;
        logic                        alt;
        logic                        force_sign;
        logic                        space;
        logic                        zpad;
        logic                        left;
    } t_fmt_setting;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [itf_pkg::VALUE_W-1:0]    i_s_axis_tdata  = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [itf_pkg::CHAR_W-1:0]     o_m_axis_tdata;
    logic                           o_m_axis_tlast;
    logic                           o_m_axis_tuser;
    logic                           i_cfg_valid     = 1'b0;
    logic                           o_cfg_ready;
    logic [itf_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [itf_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    // values waiting for the driver, characters waiting for the block
    logic [itf_pkg::VALUE_W-1:0] pending_values [$];
    t_text_char                  expected_chars [$];
    t_text_char                  want_char;

    int values_queued   = 0;
    int values_accepted = 0;
    int text_errors     = 0;

    // handshakes seen at the last rising edge
    logic value_taken = 1'b0;
    logic cfg_taken   = 1'b0;

    // no random idling on either side while set
    logic calm          = 1'b0;
    logic hold_sink_go  = 1'b0;
    logic sink_held     = 1'b0;

    // shadow copy of the format registers
    logic [itf_pkg::RADIX_W-1:0] fmt_radix;
    logic [5:0]                  fmt_width;
    logic [5:0]                  fmt_prec;
    logic                        fmt_alt;
    logic                        fmt_force;
    logic                        fmt_space;
    logic                        fmt_zero;
    logic                        fmt_left;

    integer_to_text_formatter_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [31:0] value
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] char_code
        .o_m_axis_tlast  (o_m_axis_tlast),   // last
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] error
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // builds the text of one value under the shadow registers
    function automatic void predict_text(input logic [itf_pkg::VALUE_W-1:0] raw);
        logic [itf_pkg::CHAR_W-1:0]  body [$];
        logic [itf_pkg::CHAR_W-1:0]  digits [$];
        logic                        neg;
        logic [itf_pkg::VALUE_W-1:0] mag;
        logic [itf_pkg::RADIX_W-1:0] base;
        logic [3:0]                  d;
        logic [itf_pkg::CHAR_W-1:0]  fill;
        int                          pad;
        neg = raw[itf_pkg::VALUE_W-1];
        // two's complement wrap gives 2^31 for the most negative value
        mag = neg ? (32'd0 - raw) : raw;
        base = (fmt_radix < itf_pkg::RADIX_MIN) ? itf_pkg::RADIX_MIN :
               (fmt_radix > itf_pkg::RADIX_MAX) ? itf_pkg::RADIX_MAX : fmt_radix;
        // zero still yields one digit
        do begin
            d = 4'(mag % 32'(base));
            digits.push_front((d < 4'd10) ? {4'd0, d} + itf_pkg::CH_ZERO
                                          : {4'd0, d} + itf_pkg::CH_ALPHA_OFS);
            mag = mag / 32'(base);
        end while (mag != 0);
        if (fmt_alt && base == itf_pkg::RADIX_OCT) begin
            body.push_back(itf_pkg::CH_ZERO);
        end else if (fmt_alt && base == itf_pkg::RADIX_HEX) begin
            body.push_back(itf_pkg::CH_ZERO);
            body.push_back(itf_pkg::CH_X);
        end
        // alternate form suppresses the forced plus, never the minus
        if (neg) begin
            body.push_back(itf_pkg::CH_MINUS);
        end else if (fmt_force && !fmt_alt) begin
            body.push_back(itf_pkg::CH_PLUS);
        end
        if (!neg && fmt_space) begin
            body.push_back(itf_pkg::CH_SPACE);
        end
        for (int i = digits.size(); i < int'(fmt_prec); i++) begin
            body.push_back(itf_pkg::CH_ZERO);
        end
        body = {body, digits};
        if (body.size() > itf_pkg::BUFFER_SIZE) begin
            expected_chars.push_back('{itf_pkg::CH_NUL, 1'b1, 1'b1});
            return;
        end
        // a body wider than the field is left unpadded
        pad = (fmt_width != 0 && int'(fmt_width) >= body.size()) ?
              int'(fmt_width) - body.size() : 0;
        fill = fmt_zero ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE;
        // zero padding also goes in front of prefix and sign
        if (fmt_left) begin
            repeat (pad) body.push_back(fill);
        end else begin
            repeat (pad) body.push_front(fill);
        end
        foreach (body[i]) begin
            expected_chars.push_back('{body[i], i == body.size() - 1, 1'b0});
        end
    endfunction

    // input driver: holds a value until its transfer, idles at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || value_taken) begin
            if (pending_values.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                i_s_axis_tdata  <= pending_values.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output sink: random back-pressure, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (sink_held) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // hold-off counted here so the sender keeps offering meanwhile
    initial begin
        wait (hold_sink_go);
        @(negedge i_clk);
        sink_held <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        sink_held <= 1'b0;
    end

    // monitor: register shadow, prediction on input transfers, check on output
    always @(posedge i_clk) begin
        value_taken <= i_s_axis_tvalid && o_s_axis_tready;
        cfg_taken   <= i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            fmt_radix = itf_pkg::RADIX_RESET;
            fmt_width = '0;
            fmt_prec  = '0;
            fmt_alt   = 1'b0;
            fmt_force = 1'b0;
            fmt_space = 1'b0;
            fmt_zero  = 1'b0;
            fmt_left  = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (itf_pkg::t_cfg_idx'(i_cfg_index))
                    itf_pkg::CFG_RADIX:      fmt_radix = i_cfg_data[itf_pkg::RADIX_W-1:0];
                    itf_pkg::CFG_MIN_WIDTH:  fmt_width = i_cfg_data;
                    itf_pkg::CFG_PRECISION:  fmt_prec  = i_cfg_data;
                    itf_pkg::CFG_ALT_FORM:   fmt_alt   = i_cfg_data[0];
                    itf_pkg::CFG_FORCE_SIGN: fmt_force = i_cfg_data[0];
                    itf_pkg::CFG_SPACE_FLAG: fmt_space = i_cfg_data[0];
                    itf_pkg::CFG_ZERO_PAD:   fmt_zero  = i_cfg_data[0];
                    itf_pkg::CFG_FLUSH_LEFT: fmt_left  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_text(i_s_axis_tdata);
                values_accepted++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    if (text_errors < 10) begin
                        $display("%0t: unexpected char %h last %b err %b", $realtime,
                                 o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                    end
                    text_errors++;
                end else begin
                    want_char = expected_chars.pop_front();
                    if (o_m_axis_tdata !== want_char.code || o_m_axis_tlast !== want_char.last
                            || o_m_axis_tuser !== want_char.err) begin
                        if (text_errors < 10) begin
                            $display("%0t: char expected %h last %b err %b, got %h last %b err %b",
                                     $realtime, want_char.code, want_char.last, want_char.err,
                                     o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                        end
                        text_errors++;
                    end
                end
            end
        end
    end

    // writes all eight registers, one transfer each; called only while idle
    task automatic apply_format(input t_fmt_setting f);
        @(negedge i_clk);
        for (int idx = 0; idx < 8; idx++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= itf_pkg::CFG_IDX_W'(idx);
            case (itf_pkg::t_cfg_idx'(idx))
                // spare top bit is random, the register keeps five bits
                itf_pkg::CFG_RADIX:      i_cfg_data <= {1'($urandom_range(1)), f.radix};
                itf_pkg::CFG_MIN_WIDTH:  i_cfg_data <= f.width;
                itf_pkg::CFG_PRECISION:  i_cfg_data <= f.prec;
                itf_pkg::CFG_ALT_FORM:   i_cfg_data <= {5'd0, f.alt};
                itf_pkg::CFG_FORCE_SIGN: i_cfg_data <= {5'd0, f.force_sign};
                itf_pkg::CFG_SPACE_FLAG: i_cfg_data <= {5'd0, f.space};
                itf_pkg::CFG_ZERO_PAD:   i_cfg_data <= {5'd0, f.zpad};
                default:                 i_cfg_data <= {5'd0, f.left};
            endcase
            do @(negedge i_clk); while (!cfg_taken);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic offer(input logic [itf_pkg::VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // sender pauses here until every character of the phase is back
    task automatic wait_text_drained();
        while (values_accepted != values_queued || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // timeout
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_fmt_setting                f;
        logic [itf_pkg::VALUE_W-1:0] v;
        logic [itf_pkg::VALUE_W-1:0] corner_values [4];
        corner_values = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: plain decimal, incl. zero and both extremes
        offer(32'd0);
        offer(32'd1);
        offer(32'hffff_ffff);
        offer(32'h7fff_ffff);
        offer(32'h8000_0000);
        offer(32'd12345);
        wait_text_drained();

        // hex alternate form: forced plus dropped, space kept, minus kept
        f = '{5'd16, 6'd0, 6'd0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
        apply_format(f);
        offer(32'd0);
        offer(32'hdead_beef);
        offer(32'hffff_ff01);
        wait_text_drained();

        // octal prefix with zeros padded ahead of prefix and sign
        f = '{5'd8, 6'd12, 6'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        apply_format(f);
        offer(32'd8);
        offer(32'hffff_fff8);
        wait_text_drained();

        // plus and space together, widest field, padding after the body
        f = '{5'd10, 6'd63, 6'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        apply_format(f);
        offer(32'd42);
        offer(32'hffff_ffd6);
        wait_text_drained();

        // radix below range acts as binary: longest digit string
        f = '{5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        apply_format(f);
        offer(32'h8000_0000);
        offer(32'd5);
        wait_text_drained();

        // radix above range acts as hex; top precision overflows the buffer with
        // plus and space, a minus alone just fits
        f = '{5'd31, 6'd0, 6'd63, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        apply_format(f);
        offer(32'd5);
        offer(32'hffff_ffff);
        wait_text_drained();

        // radix one acts as binary; precision zeros, then zero padding after the body
        f = '{5'd1, 6'd20, 6'd10, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
        apply_format(f);
        offer(32'd3);
        wait_text_drained();

        // field narrower than the body: no padding
        f = '{5'd16, 6'd5, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        apply_format(f);
        offer(32'h0001_2345);
        wait_text_drained();

        // random settings, random values
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(6))
                0:       f.radix = 5'd2;
                1:       f.radix = 5'd8;
                2, 3:    f.radix = 5'd10;
                4:       f.radix = 5'd16;
                5:       f.radix = 5'($urandom_range(31));
                default: f.radix = 5'($urandom_range(15, 3));
            endcase
            case ($urandom_range(9))
                0, 1:             f.width = 6'd0;
                2, 3, 4, 5, 6:    f.width = 6'($urandom_range(12));
                default:          f.width = 6'($urandom_range(63));
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: f.prec = 6'($urandom_range(6));
                6, 7, 8:          f.prec = 6'($urandom_range(40));
                default:          f.prec = 6'($urandom_range(63, 58));
            endcase
            f.alt        = 1'($urandom_range(1));
            f.force_sign = 1'($urandom_range(1));
            f.space      = 1'($urandom_range(1));
            f.zpad       = 1'($urandom_range(1));
            f.left       = 1'($urandom_range(1));
            apply_format(f);

            // one phase runs with no idling at all
            calm = (phase == 5);
            // one phase stalls the sink long enough to back up the input
            if (phase == 2) begin
                hold_sink_go = 1'b1;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(5))
                    0:       v = $urandom;
                    1:       v = 32'($urandom_range(40));
                    2:       v = 32'd0 - 32'($urandom_range(40, 1));
                    3:       v = corner_values[$urandom_range(3)];
                    default: begin
                        v = $urandom >> $urandom_range(31);
                        if ($urandom_range(1)) begin
                            v = 32'd0 - v;
                        end
                    end
                endcase
                offer(v);
            end
            wait_text_drained();
            calm = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (text_errors == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
